/* rtl/core/omp_pkg.sv */
// Shared types and constants for the OSC message parser.
package omp_pkg;

  // Status codes carried by the end-of-packet result
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOT_MSG  = 3'd1;
  localparam logic [2:0] ST_NO_TYPE  = 3'd2;
  localparam logic [2:0] ST_TOO_LONG = 3'd3;
  localparam logic [2:0] ST_TOO_MANY = 3'd4;
  localparam logic [2:0] ST_TRUNC    = 3'd5;

  // Result kinds
  localparam logic KIND_ARG    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // ASCII characters the parser looks for
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h54;

  // IEEE single constants
  localparam logic [7:0]  FP_BIAS    = 8'd127;
  localparam logic [7:0]  FP_EXP_MAX = 8'hFF;
  localparam logic [7:0]  FP_EXP_SAT = 8'd158;
  localparam logic [22:0] FP_FRAC_M  = 23'h7FFFFF;

  typedef struct packed {
    logic               result_kind;
    logic [3:0]         arg_number;
    logic [7:0]         arg_type;
    logic [7:0]         arg_offset;
    logic [7:0]         arg_length;
    logic [31:0]        raw_word;
    logic signed [31:0] int_value;
    logic               bool_value;
    logic [2:0]         status;
    logic [7:0]         address_length;
    logic [4:0]         arg_total;
    logic               last_result;
  } result_t;

endpackage

/* rtl/core/osc_message_parser_core.sv */
// OSC message parser: byte stream in, argument descriptors and packet status out.
//
// Usage:
//   Feed the bytes of one OSC message on the in_ channel, one word per
//   handshake, with in_last_byte set on the final byte of the packet. Each
//   word is taken when in_valid is high and in_stall is low.
//   The out_ channel carries result words: an argument descriptor for each
//   tag (tags without data as soon as the tag byte arrives, i/f/s once their
//   data is complete) and one status word per packet after its final byte.
//   out_last_result marks the final result caused by one input byte.
//   A result enters the result queue when the byte causing it is taken.
//   Throughput: one byte per cycle while in_stall is low; a byte that causes two
//   results (a descriptor plus the status) pushes both words at once, which the
//   result queue absorbs. All parsing of a byte is a single pass of logic
//   between the parse registers and a four-word result queue.
//   in_stall rises when the queue has fewer than two free entries, so a
//   stalled receiver backs up into the sender after at most a few words.
//   Reset (rst_n low, synchronous) empties the queue and returns the parser
//   to the address phase; the final byte of a packet also clears the parser state.
module osc_message_parser_core
  import omp_pkg::*;
#(
  parameter int PACKET_BYTES = 256,
  parameter int ARG_SLOTS    = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_result_kind,
  output logic [3:0]         out_arg_number,
  output logic [7:0]         out_arg_type,
  output logic [7:0]         out_arg_offset,
  output logic [7:0]         out_arg_length,
  output logic [31:0]        out_raw_word,
  output logic signed [31:0] out_int_value,
  output logic               out_bool_value,
  output logic [2:0]         out_status,
  output logic [7:0]         out_address_length,
  output logic [4:0]         out_arg_total,
  output logic               out_last_result
);

  // Byte position saturates at PACKET_BYTES
  localparam int POS_W = $clog2(PACKET_BYTES + 1);
  // Argument start may run past the packet end (type string padding)
  localparam int AS_W  = $clog2(PACKET_BYTES + 4 * ARG_SLOTS + 8);
  localparam int CNT_W = $clog2(ARG_SLOTS + 1);
  localparam int IDX_W = (ARG_SLOTS > 1) ? $clog2(ARG_SLOTS) : 1;

  // Parse phases
  localparam logic [2:0] PH_ADDR  = 3'd0;
  localparam logic [2:0] PH_COMMA = 3'd1;
  localparam logic [2:0] PH_TYPES = 3'd2;
  localparam logic [2:0] PH_PAD   = 3'd3;
  localparam logic [2:0] PH_ARGS  = 3'd4;

  // Stored tag classes: only the data-carrying tags need their letter kept
  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_I    = 2'd1;
  localparam logic [1:0] CLS_F    = 2'd2;
  localparam logic [1:0] CLS_S    = 2'd3;

  // Result queue
  localparam int QD   = 4;
  localparam int QA_W = $clog2(QD);
  localparam int QC_W = $clog2(QD + 1);

  logic [2:0]                 phase_r, phase_nxt;
  logic [POS_W-1:0]           pos_r, pos_nxt;
  logic [POS_W-1:0]           alen_r, alen_nxt;
  logic [POS_W-1:0]           tstart_r, tstart_nxt;
  logic [ARG_SLOTS-1:0][1:0]  cls_r, cls_nxt;
  logic [CNT_W-1:0]           tcount_r, tcount_nxt;
  logic [CNT_W-1:0]           cur_r, cur_nxt;
  logic [AS_W-1:0]            astart_r, astart_nxt;
  logic [POS_W-1:0]           abc_r, abc_nxt;
  logic [31:0]                wsh_r, wsh_nxt;
  logic [2:0]                 err_r, err_nxt;

  logic                       desc_v;
  result_t                    desc_w;
  result_t                    stat_w;
  logic [2:0]                 st_code;
  logic [1:0]                 cur_cls;
  logic [7:0]                 cur_tag;
  logic                       arg_done;
  logic [7:0]                 done_len;
  logic [31:0]                done_raw;
  logic [31:0]                done_int;
  logic [1:0]                 new_cls;

  result_t                    q_r [QD];
  logic [QA_W-1:0]            wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0]            q_cnt_r;
  logic                       in_accept;
  logic                       pop;
  logic                       push0, push1;
  result_t                    push0_w;

  // First data-carrying tag at or after 'from'; the tag count if none
  function automatic logic [CNT_W-1:0] next_data(
    input logic [ARG_SLOTS-1:0][1:0] cls,
    input logic [CNT_W-1:0]          from,
    input logic [CNT_W-1:0]          cnt
  );
    logic [CNT_W-1:0] res;
    res = cnt;
    for (int k = ARG_SLOTS - 1; k >= 0; k--) begin
      if (cls[k] != CLS_NONE && k >= int'(from)) begin
        res = CNT_W'(k);
      end
    end
    return res;
  endfunction

  // IEEE single to int32, truncate toward zero, saturate, NaN to zero
  function automatic logic [31:0] float_to_int(input logic [31:0] w);
    logic [7:0]  ef;
    logic [7:0]  e8;
    logic [23:0] mant;
    logic [53:0] sh;
    logic [30:0] mag;
    logic [31:0] res;
    ef   = w[30:23];
    e8   = ef - FP_BIAS;
    mant = {1'b1, w[22:0]};
    sh   = {30'd0, mant} << e8[4:0];
    mag  = sh[53:23];
    if (ef == FP_EXP_MAX && (w[22:0] & FP_FRAC_M) != 23'd0) begin
      res = 32'd0;
    end else if (ef < FP_BIAS) begin
      res = 32'd0;
    end else if (ef >= FP_EXP_SAT) begin
      res = w[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      res = w[31] ? (32'd0 - {1'b0, mag}) : {1'b0, mag};
    end
    return res;
  endfunction

  assign in_accept = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  // Classify the incoming tag byte
  always_comb begin
    case (in_data_byte)
      CH_I:    new_cls = CLS_I;
      CH_F:    new_cls = CLS_F;
      CH_S:    new_cls = CLS_S;
      default: new_cls = CLS_NONE;
    endcase
  end

  // Tag of the argument now taking data bytes
  assign cur_cls = cls_r[cur_r[IDX_W-1:0]];
  always_comb begin
    case (cur_cls)
      CLS_I:   cur_tag = CH_I;
      CLS_F:   cur_tag = CH_F;
      CLS_S:   cur_tag = CH_S;
      default: cur_tag = CH_NUL;
    endcase
  end

  // One pass of the parser over the offered byte
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    alen_nxt   = alen_r;
    tstart_nxt = tstart_r;
    cls_nxt    = cls_r;
    tcount_nxt = tcount_r;
    cur_nxt    = cur_r;
    astart_nxt = astart_r;
    abc_nxt    = abc_r;
    wsh_nxt    = wsh_r;
    err_nxt    = err_r;
    desc_v     = 1'b0;
    desc_w     = '0;
    arg_done   = 1'b0;
    done_len   = 8'd0;
    done_raw   = 32'd0;
    done_int   = 32'd0;

    if (err_r == ST_OK) begin
      if (pos_r >= POS_W'(PACKET_BYTES)) begin
        err_nxt = ST_TOO_LONG;
      end else begin
        case (phase_r)
          PH_ADDR: begin
            if (pos_r == '0 && in_data_byte != CH_SLASH) begin
              err_nxt = ST_NOT_MSG;
            end else if (in_data_byte == CH_NUL) begin
              alen_nxt  = pos_r;
              phase_nxt = PH_COMMA;
            end
          end
          PH_COMMA: begin
            if (in_data_byte == CH_COMMA) begin
              tstart_nxt = pos_r;
              phase_nxt  = PH_TYPES;
            end
          end
          PH_TYPES: begin
            if (in_data_byte == CH_NUL) begin
              // data starts after the comma, the tags and the NUL, padded to 4
              astart_nxt = AS_W'(tstart_r)
                         + AS_W'(((32'(tcount_r) + 32'd1) >> 2) + 32'd1) * AS_W'(4);
              cur_nxt    = next_data(cls_r, '0, tcount_r);
              phase_nxt  = PH_PAD;
            end else if (tcount_r >= CNT_W'(ARG_SLOTS)) begin
              err_nxt = ST_TOO_MANY;
            end else begin
              cls_nxt[tcount_r[IDX_W-1:0]] = new_cls;
              if (new_cls == CLS_NONE) begin
                // tag without data: report at once
                desc_v                = 1'b1;
                desc_w.result_kind    = KIND_ARG;
                desc_w.arg_number     = 4'(tcount_r);
                desc_w.arg_type       = in_data_byte;
                desc_w.bool_value     = (in_data_byte == CH_T);
              end
              tcount_nxt = tcount_r + CNT_W'(1);
            end
          end
          default: begin
            if (phase_r == PH_PAD && AS_W'(pos_r) == astart_r) begin
              phase_nxt = PH_ARGS;
              abc_nxt   = '0;
              wsh_nxt   = 32'd0;
            end
            if (phase_nxt == PH_ARGS && cur_r < tcount_r) begin
              if (abc_nxt == '0) begin
                astart_nxt = AS_W'(pos_r);
              end
              abc_nxt = abc_nxt + POS_W'(1);
              if (cur_cls == CLS_S) begin
                if (wsh_nxt == 32'd0 && in_data_byte == CH_NUL) begin
                  wsh_nxt = (((32'(abc_nxt) - 32'd1) >> 2) + 32'd1) << 2;
                end
                if (wsh_nxt != 32'd0 && 32'(abc_nxt) == wsh_nxt) begin
                  arg_done = 1'b1;
                  done_len = 8'(wsh_nxt);
                end
              end else begin
                wsh_nxt = {wsh_nxt[23:0], in_data_byte};
                if (abc_nxt == POS_W'(4)) begin
                  arg_done = 1'b1;
                  done_len = 8'd4;
                  done_raw = wsh_nxt;
                  done_int = (cur_cls == CLS_F) ? float_to_int(wsh_nxt) : wsh_nxt;
                end
              end
              if (arg_done) begin
                desc_v             = 1'b1;
                desc_w.result_kind = KIND_ARG;
                desc_w.arg_number  = 4'(cur_r);
                desc_w.arg_type    = cur_tag;
                desc_w.arg_offset  = 8'(astart_nxt);
                desc_w.arg_length  = done_len;
                desc_w.raw_word    = done_raw;
                desc_w.int_value   = done_int;
                cur_nxt            = next_data(cls_r, cur_r + CNT_W'(1), tcount_r);
                abc_nxt            = '0;
                wsh_nxt            = 32'd0;
              end
            end
          end
        endcase
      end
    end

    if (pos_r < POS_W'(PACKET_BYTES)) begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  // End-of-packet status: first error wins, else judge where parsing stopped
  always_comb begin
    if (err_nxt != ST_OK) begin
      st_code = err_nxt;
    end else if (phase_nxt == PH_ADDR || phase_nxt == PH_TYPES) begin
      st_code = ST_TRUNC;
    end else if (phase_nxt == PH_COMMA) begin
      st_code = ST_NO_TYPE;
    end else begin
      st_code = (cur_nxt < tcount_nxt) ? ST_TRUNC : ST_OK;
    end
    stat_w                = '0;
    stat_w.result_kind    = KIND_STATUS;
    stat_w.status         = st_code;
    stat_w.address_length = 8'(alen_nxt);
    stat_w.arg_total      = 5'(tcount_nxt);
    stat_w.last_result    = 1'b1;
  end

  // Parser state: advance on each taken byte, clear after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (in_accept && in_last_byte)) begin
      phase_r  <= PH_ADDR;
      pos_r    <= '0;
      alen_r   <= '0;
      tstart_r <= '0;
      cls_r    <= '0;
      tcount_r <= '0;
      cur_r    <= '0;
      astart_r <= '0;
      abc_r    <= '0;
      wsh_r    <= 32'd0;
      err_r    <= ST_OK;
    end else if (in_accept) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      alen_r   <= alen_nxt;
      tstart_r <= tstart_nxt;
      cls_r    <= cls_nxt;
      tcount_r <= tcount_nxt;
      cur_r    <= cur_nxt;
      astart_r <= astart_nxt;
      abc_r    <= abc_nxt;
      wsh_r    <= wsh_nxt;
      err_r    <= err_nxt;
    end
  end

  // Result queue: up to two words in per byte, one word out per cycle while out_stall is low
  assign push0 = in_accept && (desc_v || in_last_byte);
  assign push1 = in_accept && desc_v && in_last_byte;

  always_comb begin
    push0_w = desc_v ? desc_w : stat_w;
    // a lone descriptor is the final result of its byte
    if (desc_v && !in_last_byte) begin
      push0_w.last_result = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      q_r[wr_ptr_r] <= push0_w;
    end
    if (push1) begin
      q_r[wr_ptr_r + QA_W'(1)] <= stat_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QA_W'(push0) + QA_W'(push1);
      rd_ptr_r <= rd_ptr_r + QA_W'(pop);
      q_cnt_r  <= q_cnt_r + QC_W'(push0) + QC_W'(push1) - QC_W'(pop);
    end
  end

  // Hold off the sender unless two words fit
  assign in_stall  = (q_cnt_r > QC_W'(QD - 2));
  assign out_valid = (q_cnt_r != '0);

  assign out_result_kind    = q_r[rd_ptr_r].result_kind;
  assign out_arg_number     = q_r[rd_ptr_r].arg_number;
  assign out_arg_type       = q_r[rd_ptr_r].arg_type;
  assign out_arg_offset     = q_r[rd_ptr_r].arg_offset;
  assign out_arg_length     = q_r[rd_ptr_r].arg_length;
  assign out_raw_word       = q_r[rd_ptr_r].raw_word;
  assign out_int_value      = q_r[rd_ptr_r].int_value;
  assign out_bool_value     = q_r[rd_ptr_r].bool_value;
  assign out_status         = q_r[rd_ptr_r].status;
  assign out_address_length = q_r[rd_ptr_r].address_length;
  assign out_arg_total      = q_r[rd_ptr_r].arg_total;
  assign out_last_result    = q_r[rd_ptr_r].last_result;

endmodule

/* rtl/core/omp_checker.sv */
// Port-level checks for the OSC message parser, bound to the parser core.
module omp_checker
  import omp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_result_kind,
  input logic [7:0]  out_arg_type,
  input logic        out_bool_value,
  input logic [2:0]  out_status,
  input logic [7:0]  out_address_length,
  input logic [4:0]  out_arg_total,
  input logic        out_last_result
);

  // A stalled word stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // Status word always closes the results of its byte
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_STATUS |-> out_last_result)
    else $error("status word not marked last");

  // Descriptors carry no packet summary
  a_desc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_ARG |->
      out_status == ST_OK && out_address_length == 8'd0 && out_arg_total == 5'd0)
    else $error("descriptor carries status fields");

  // Boolean true only on a T descriptor
  a_bool_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bool_value |-> out_result_kind == KIND_ARG && out_arg_type == CH_T)
    else $error("boolean set on a non-T result");

  // Status code in range
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_STATUS |-> out_status <= ST_TRUNC)
    else $error("status code out of range");

endmodule

bind osc_message_parser_core omp_checker u_omp_checker (.*);
